### rtl/core/ber_pkg.sv
package ber_pkg;

  localparam int unsigned MAX_BYTES  = 32'd16777216;
  localparam int unsigned BINS       = 256;
  localparam int unsigned BIN_W      = 8;
  localparam int unsigned CNT_W      = 25;
  localparam logic [CNT_W-1:0] COUNT_LIMIT =
    (MAX_BYTES > 33554431) ? 25'h1FFFFFF : MAX_BYTES[CNT_W-1:0];
  localparam int unsigned LOG_W      = 35;  // k (5 bits) . 30 fraction bits
  localparam int unsigned ACC_W      = 61;
  localparam int unsigned ENT_W      = 20;
  localparam int unsigned RAT_W      = 17;
  localparam logic [ENT_W-1:0] ENTROPY_MAX = 20'd524288;
  localparam logic [RAT_W-1:0] RATIO_ONE   = 17'd65536;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = 2;

  // one classified beat handed from front to back
  typedef struct packed {
    logic [BIN_W-1:0] byte_value;
    logic             carries_byte;
    logic             last;
  } beat_t;

endpackage

### rtl/core/ber_front.sv
module ber_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [7:0]    in_byte_value,
  input  logic          in_carries_byte,
  input  logic          in_last,
  output logic          q_valid,
  output ber_pkg::beat_t q_beat,
  input  logic          q_pop
);
  import ber_pkg::*;

  beat_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   fill_r, fill_nxt;
  logic              push;

  assign busy    = (fill_r == (QPTR_W+1)'(QDEPTH)) ? 1'b1 : 1'b0;
  assign push    = start && !busy && (in_carries_byte || in_last);
  assign q_valid = (fill_r != '0);
  assign q_beat  = mem_r[rd_r];

  // fill count
  always_comb begin
    fill_nxt = fill_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop && q_valid);
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= '{byte_value: in_byte_value, carries_byte: in_carries_byte,
                       last: in_last};
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; fill_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (q_pop && q_valid) rd_r <= rd_r + 1'b1;
      fill_r <= fill_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (QPTR_W+1)'(QDEPTH)) else $error("queue overfilled");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !push) else $error("push into full queue");
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> fill_r == $past(fill_r) + 1'b1) else $error("fill step");

endmodule

### rtl/core/ber_log2.sv
module ber_log2 (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  logic [ber_pkg::CNT_W-1:0] x,
  output logic                   done,
  output logic [ber_pkg::LOG_W-1:0] y
);
  import ber_pkg::*;

  logic [32:0] m_r, m_nxt;
  logic [29:0] frac_r;
  logic [4:0]  k_r, k_c;
  logic [4:0]  it_r;
  logic        run_r;
  logic [65:0] sq;
  logic [31:0] xw;

  assign xw = 32'(x);

  // top set bit
  always_comb begin
    k_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (xw[i]) k_c = 5'(i);
    end
  end

  // one square-and-compare step per cycle
  assign sq    = 66'(m_r) * 66'(m_r);
  assign m_nxt = sq[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; done <= 1'b0; it_r <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run_r  <= 1'b1;
        it_r   <= '0;
        k_r    <= k_c;
        m_r    <= {1'b0, xw << (5'd31 - k_c)};
        frac_r <= '0;
      end else if (run_r) begin
        if (m_nxt[32]) begin
          m_r <= {1'b0, m_nxt[32:1]};
        end else begin
          m_r <= m_nxt;
        end
        frac_r <= {frac_r[28:0], m_nxt[32]};
        it_r   <= it_r + 1'b1;
        if (it_r == 5'd29) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  assign y = {k_r, frac_r};

endmodule

### rtl/core/ber_back.sv
module ber_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ber_pkg::beat_t q_beat,
  output logic           q_pop,
  output logic           out_valid,
  output logic [16:0]    out_ratio_q16,
  output logic [19:0]    out_entropy_q16,
  output logic [24:0]    out_byte_count,
  output logic           out_overflow
);
  import ber_pkg::*;

  typedef enum logic [7:0] {
    S_RUN   = 8'b0000_0001,
    S_CLR   = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_LOG   = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_BIN   = 8'b1000_0000
  } st_t;

  st_t              st_r;
  logic [CNT_W-1:0] hist [BINS];
  logic [CNT_W-1:0] raw_q, fwd_r, bump_val, bin_val, cnt_r, c_r;
  logic [BINS-1:0]  vld_r;
  logic [BIN_W-1:0] idx_r, rd_addr, bump_addr_r;
  logic             ovf_r, binph_r, a_done_r, bump_r, fwd_hit_r;
  logic [ACC_W-1:0] a_r, s_r, num_r, prod, s_sum;
  logic [35:0]      quo_r;
  logic [5:0]       dcnt_r;
  logic [CNT_W:0]   rem_r, rem_sh;
  logic             lgo, ldone, accept_byte;
  logic [LOG_W-1:0] ly;

  ber_log2 u_log (.clk, .rst_n, .go(lgo), .x(c_r), .done(ldone), .y(ly));

  assign q_pop       = (st_r == S_RUN) && q_valid;
  assign accept_byte = q_pop && q_beat.carries_byte && (cnt_r < COUNT_LIMIT);
  assign rd_addr     = (st_r == S_RUN) ? q_beat.byte_value : idx_r;
  assign bin_val     = vld_r[idx_r] ? raw_q : '0;
  assign prod        = ACC_W'(c_r) * ACC_W'(ly);
  assign s_sum       = s_r + prod;
  assign lgo         = (st_r == S_RD);
  assign rem_sh      = {rem_r[CNT_W-1:0], num_r[ACC_W-1]};

  // new bin value: forwarded when the same bin was bumped the cycle before
  assign bump_val = (fwd_hit_r ? fwd_r : (vld_r[bump_addr_r] ? raw_q : '0)) + 1'b1;

  // histogram: registered read, one bump written per cycle
  always_ff @(posedge clk) begin
    raw_q <= hist[rd_addr];
    if (bump_r) begin
      hist[bump_addr_r] <= bump_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_RUN; vld_r <= '0; cnt_r <= '0; ovf_r <= 1'b0; out_valid <= 1'b0;
      bump_r <= 1'b0; fwd_hit_r <= 1'b0;
    end else begin
      out_valid   <= 1'b0;
      bump_r      <= accept_byte;
      bump_addr_r <= q_beat.byte_value;
      fwd_hit_r   <= bump_r && accept_byte && (bump_addr_r == q_beat.byte_value);
      fwd_r       <= bump_val;
      if (bump_r) begin
        vld_r[bump_addr_r] <= 1'b1;
      end
      case (st_r)
        S_RUN: begin
          if (q_pop) begin
            if (q_beat.carries_byte) begin
              if (cnt_r < COUNT_LIMIT) cnt_r <= cnt_r + 1'b1;
              else ovf_r <= 1'b1;
            end
            if (q_beat.last) st_r <= S_CLR;
          end
        end
        S_CLR: begin
          // drain the last bump, then start with the total
          a_done_r <= 1'b0; s_r <= '0; idx_r <= '0; c_r <= cnt_r;
          binph_r <= 1'b0;
          if (!bump_r) st_r <= (cnt_r == '0) ? S_OUT : S_RD;
        end
        S_RD: st_r <= S_LOG;
        S_LOG: if (ldone) st_r <= S_MUL;
        S_MUL: begin
          if (!binph_r) begin
            a_r <= prod; binph_r <= 1'b1; st_r <= S_BIN;
          end else begin
            s_r <= s_sum;
            if (idx_r == BIN_W'(BINS-1)) begin
              st_r <= S_DIV; dcnt_r <= '0; rem_r <= '0; quo_r <= '0;
              num_r <= (s_sum > a_r) ? '0 : a_r - s_sum;
            end else begin
              idx_r <= idx_r + 1'b1; st_r <= S_BIN;
            end
          end
        end
        S_BIN: begin
          // fetch the registered bin first, then use it; skip empty bins
          if (a_done_r) begin
            c_r <= bin_val;
            a_done_r <= 1'b0;
            if (bin_val == '0) begin
              if (idx_r == BIN_W'(BINS-1)) begin
                st_r <= S_DIV; dcnt_r <= '0; rem_r <= '0; quo_r <= '0;
                num_r <= (s_r > a_r) ? '0 : a_r - s_r;
              end else idx_r <= idx_r + 1'b1;
            end else st_r <= S_RD;
          end else a_done_r <= 1'b1;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          num_r <= {num_r[ACC_W-2:0], 1'b0};
          if (rem_sh >= {1'b0, cnt_r}) begin
            rem_r <= rem_sh - {1'b0, cnt_r}; quo_r <= {quo_r[34:0], 1'b1};
          end else begin
            rem_r <= rem_sh; quo_r <= {quo_r[34:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 6'(ACC_W-1)) st_r <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          if (cnt_r == '0) begin
            out_ratio_q16 <= RATIO_ONE; out_entropy_q16 <= '0;
          end else begin
            out_entropy_q16 <= (quo_r[35:14] > 22'(ENTROPY_MAX)) ? ENTROPY_MAX
                               : quo_r[33:14];
            out_ratio_q16   <= (quo_r[35:17] > 19'(RATIO_ONE)) ? RATIO_ONE
                               : quo_r[33:17];
          end
          out_byte_count <= cnt_r; out_overflow <= ovf_r;
          cnt_r <= '0; ovf_r <= 1'b0; vld_r <= '0;
          st_r <= S_RUN;
        end
        default: st_r <= S_RUN;
      endcase
    end
  end

  a_pop_run: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == S_RUN) else $error("pop outside run");
  a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_cnt_lim: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= COUNT_LIMIT) else $error("count above limit");

endmodule

### rtl/core/byte_entropy_ratio_estimator_unit.sv
// byte entropy estimator: one byte beat per cycle into the histogram while busy is low
// a last beat starts a walk of all 256 bins: an empty bin is fetched and skipped, a nonzero
// bin goes through the shared square-and-compare log2 unit, then a restoring divider runs
// an empty block skips the walk and goes straight to the result strobe
// receiver cannot stall; synchronous active-low reset clears counts, flags and bin valid bits
module byte_entropy_ratio_estimator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_byte_value,
  input  logic        in_carries_byte,
  input  logic        in_last,
  output logic        out_valid,
  output logic [16:0] out_ratio_q16,
  output logic [19:0] out_entropy_q16,
  output logic [24:0] out_byte_count,
  output logic        out_overflow
);
  import ber_pkg::*;

  beat_t q_beat;
  logic  q_valid, q_pop;

  ber_front u_front (.clk, .rst_n, .start, .busy, .in_byte_value, .in_carries_byte,
    .in_last, .q_valid, .q_beat, .q_pop);

  ber_back u_back (.clk, .rst_n, .q_valid, .q_beat, .q_pop, .out_valid,
    .out_ratio_q16, .out_entropy_q16, .out_byte_count, .out_overflow);

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ber_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct {
    logic [16:0] ratio_q16;
    logic [19:0] entropy_q16;
    logic [24:0] byte_count;
    logic        overflow;
  } entropy_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_byte_value;
  logic        in_carries_byte;
  logic        in_last;
  logic        out_valid;
  logic [16:0] out_ratio_q16;
  logic [19:0] out_entropy_q16;
  logic [24:0] out_byte_count;
  logic        out_overflow;

  byte_entropy_ratio_estimator_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_byte_value   (in_byte_value),
    .in_carries_byte (in_carries_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ratio_q16   (out_ratio_q16),
    .out_entropy_q16 (out_entropy_q16),
    .out_byte_count  (out_byte_count),
    .out_overflow    (out_overflow)
  );

  beat_t           pending_beats[$];
  entropy_result_t expected_results[$];
  int unsigned     error_count;
  int unsigned     cycle_count;
  int unsigned     sender_idle_pct;
  bit              beat_taken;

  // predictor state for the current block
  logic [24:0] bin_count[BINS];
  logic [24:0] block_total;
  logic        block_dropped;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // log2 in unsigned Q.30 by repeated squaring of the normalized mantissa
  function automatic logic [63:0] log2_fixed(input logic [24:0] x);
    int          top;
    logic [63:0] mant;
    logic [63:0] frac;
    top = 0;
    frac = 0;
    if (x == 0) begin
      return 64'd0;
    end
    for (int b = 0; b < 25; b++) begin
      if (x[b]) begin
        top = b;
      end
    end
    mant = 64'(x) << (31 - top);
    for (int i = 0; i < 30; i++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(top) << 30) | frac;
  endfunction

  // clear the histogram after each result
  task automatic clear_block();
    for (int i = 0; i < BINS; i++) begin
      bin_count[i] = '0;
    end
    block_total = '0;
    block_dropped = 1'b0;
  endtask

  // fold one accepted beat into the histogram, form the entropy on last
  task automatic predict_entropy(input beat_t bt);
    entropy_result_t r;
    logic [63:0]     a_sum;
    logic [63:0]     s_sum;
    logic [63:0]     h;
    logic [63:0]     ent;
    logic [63:0]     rat;
    if (bt.carries_byte) begin
      if (block_total >= COUNT_LIMIT) begin
        block_dropped = 1'b1;
      end else begin
        bin_count[bt.byte_value]++;
        block_total++;
      end
    end
    if (bt.last) begin
      if (block_total == 0) begin
        ent = 0;
        rat = RATIO_ONE;
      end else begin
        a_sum = 64'(block_total) * log2_fixed(block_total);
        s_sum = 0;
        for (int i = 0; i < BINS; i++) begin
          if (bin_count[i] != 0) begin
            s_sum += 64'(bin_count[i]) * log2_fixed(bin_count[i]);
          end
        end
        h = (s_sum > a_sum) ? 64'd0 : (a_sum - s_sum) / 64'(block_total);
        ent = h >> 14;
        rat = h >> 17;
        if (ent > ENTROPY_MAX) ent = ENTROPY_MAX;
        if (rat > RATIO_ONE) rat = RATIO_ONE;
      end
      r.ratio_q16 = rat[16:0];
      r.entropy_q16 = ent[19:0];
      r.byte_count = block_total;
      r.overflow = block_dropped;
      expected_results.push_back(r);
      clear_block();
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic push_beat(input logic [7:0] b, input logic has, input logic lst);
    beat_t bt;
    bt.byte_value = b;
    bt.carries_byte = has;
    bt.last = lst;
    pending_beats.push_back(bt);
  endtask

  // one random block: skewed or wide alphabets, stray markers, either ending
  task automatic gen_block();
    int          len;
    int          kind;
    logic [7:0]  base;
    logic [7:0]  span;
    kind = $urandom_range(0, 19);
    base = 8'($urandom);
    span = 8'($urandom_range(0, 255));
    if (kind == 0) begin
      len = 0;
    end else if (kind == 1) begin
      len = $urandom_range(100, 300);
    end else if (kind < 6) begin
      span = 8'($urandom_range(0, 3));
      len = $urandom_range(1, 20);
    end else begin
      len = $urandom_range(1, 20);
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_beat(8'($urandom), 1'b0, 1'b0);
      end
      push_beat(base + 8'($urandom_range(0, span)), 1'b1, 1'b0);
    end
    if ($urandom_range(0, 1) == 0) begin
      push_beat(8'($urandom), 1'b0, 1'b1);
    end else begin
      push_beat(8'($urandom), 1'b1, 1'b1);
    end
  endtask

  // permutation of all byte values: the maximum entropy block
  task automatic gen_full_spread();
    logic [7:0] perm[256];
    int         j;
    logic [7:0] tmp;
    for (int i = 0; i < 256; i++) perm[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < 256; i++) begin
      push_beat(perm[i], 1'b1, i == 255);
    end
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // sample handshakes and results at the rising edge
  always @(posedge clk) begin
    entropy_result_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
    beat_taken = 1'b0;
    if (rst_n && start && !busy) begin
      beat_taken = 1'b1;
      predict_entropy(beat_t'{in_byte_value, in_carries_byte, in_last});
    end
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_ratio_q16 !== want.ratio_q16)
          report_mismatch("ratio_q16", out_ratio_q16, want.ratio_q16);
        if (out_entropy_q16 !== want.entropy_q16)
          report_mismatch("entropy_q16", out_entropy_q16, want.entropy_q16);
        if (out_byte_count !== want.byte_count)
          report_mismatch("byte_count", out_byte_count, want.byte_count);
        if (out_overflow !== want.overflow)
          report_mismatch("overflow", out_overflow, want.overflow);
      end
    end
  end

  // drive the next beat at the falling edge
  always @(negedge clk) begin
    logic go;
    if (beat_taken) begin
      void'(pending_beats.pop_front());
      beat_taken = 1'b0;
    end
    go = rst_n && pending_beats.size() != 0 &&
         ($urandom_range(0, 99) >= sender_idle_pct);
    start <= go;
    if (go) begin
      in_byte_value <= pending_beats[0].byte_value;
      in_carries_byte <= pending_beats[0].carries_byte;
      in_last <= pending_beats[0].last;
    end
  end

  initial begin
    start = 1'b0;
    in_byte_value = '0;
    in_carries_byte = 1'b0;
    in_last = 1'b0;
    rst_n = 1'b0;
    error_count = 0;
    cycle_count = 0;
    beat_taken = 1'b0;
    sender_idle_pct = 0;
    clear_block();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty block, lone marker, byte extremes, repeats, last with byte
    push_beat(8'h00, 1'b0, 1'b1);
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'h00, 1'b1, 1'b1);
    push_beat(8'hFF, 1'b1, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b1);
    push_beat(8'h55, 1'b1, 1'b0);
    push_beat(8'h55, 1'b1, 1'b0);
    push_beat(8'h55, 1'b1, 1'b1);
    push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'hFF, 1'b1, 1'b1);
    push_beat(8'hAA, 1'b1, 1'b0);
    push_beat(8'h01, 1'b1, 1'b0);
    push_beat(8'h80, 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'hAA, 1'b1, 1'b1);
    wait_idle();

    // random phases, the sender pausing for a full drain between them
    sender_idle_pct = 32;
    gen_full_spread();
    while (pending_beats.size() < 300) gen_block();
    wait_idle();
    sender_idle_pct = 60;
    while (pending_beats.size() < 300) gen_block();
    wait_idle();
    sender_idle_pct = 0;
    while (pending_beats.size() < 300) gen_block();
    gen_full_spread();
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ber_pkg.sv
rtl/core/ber_front.sv
rtl/core/ber_log2.sv
rtl/core/ber_back.sv
rtl/core/byte_entropy_ratio_estimator_unit.sv
test/tb_top.sv
